>>> rtl/rmj_pkg.sv
// shared types, widths and helpers for the radar measurement jacobian
`default_nettype none
package rmj_pkg;

  localparam int DW         = 32;             // data word width
  localparam int FB         = 16;             // fractional bits
  localparam int CFG_W      = 48;             // threshold register width
  localparam int SQ_W       = 2 * DW;         // range squared width
  localparam int SQ_STAGES  = DW;             // one root bit per stage
  localparam int DIV_QB     = DW;             // quotient bits before saturation
  localparam int DIV_STAGES = DIV_QB + 1;     // overflow check plus one bit per stage
  localparam int DIV_DW     = 3 * DW;         // widest divisor (range cubed)
  localparam int DIV_NW     = 3 * DW + FB;    // widest numerator
  localparam int DIV_RW     = DIV_DW + DIV_QB; // remainder and shifted divisor width
  localparam logic [CFG_W-1:0] MIN_RANGE_SQ_RST = CFG_W'(7);

  typedef struct packed {
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] vel_x;
    logic signed [DW-1:0] vel_y;
  } rmj_in_t;

  typedef struct packed {
    logic signed [DW-1:0] range_dpx;
    logic signed [DW-1:0] range_dpy;
    logic signed [DW-1:0] bearing_dpx;
    logic signed [DW-1:0] bearing_dpy;
    logic signed [DW-1:0] rate_dpx;
    logic signed [DW-1:0] rate_dpy;
    logic                 div_error;
  } rmj_out_t;

  // side data that rides along the square root pipeline
  typedef struct packed {
    logic            err;
    logic [SQ_W-1:0] r2;
    logic [DW-1:0]   px_m;
    logic [DW-1:0]   py_m;
    logic            px_n;
    logic            py_n;
    logic [SQ_W-1:0] cr_m;
    logic            cr_n;
  } rmj_sq_pl_t;

  function automatic logic [DW-1:0] rmj_mag(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rmj_sqrt.sv
// pipelined integer square root, one root bit per stage, with side data
`default_nettype none
module rmj_sqrt import rmj_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  rmj_sq_pl_t    in_pl,
  output logic          out_vld,
  output rmj_sq_pl_t    out_pl,
  output logic [DW-1:0] out_root
);

  logic              vld_r  [SQ_STAGES];
  logic [SQ_W-1:0]   x_r    [SQ_STAGES];
  logic [DW-1:0]     root_r [SQ_STAGES];
  rmj_sq_pl_t        pl_r   [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
    localparam int BIT = SQ_STAGES - 1 - k;
    logic              v_in;
    logic [SQ_W-1:0]   x_in;
    logic [DW-1:0]     root_in;
    rmj_sq_pl_t        pl_in;
    logic [SQ_W+1:0]   trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in    = in_vld;
      assign x_in    = in_pl.r2;
      assign root_in = '0;
      assign pl_in   = in_pl;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign x_in    = x_r[k-1];
      assign root_in = root_r[k-1];
      assign pl_in   = pl_r[k-1];
    end

    // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
    assign trial = ((SQ_W+2)'(root_in) << (BIT + 1)) + ((SQ_W+2)'(1) << (2 * BIT));
    assign take  = ((SQ_W+2)'(x_in) >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= take ? (x_in - trial[SQ_W-1:0]) : x_in;
        root_r[k] <= take ? (root_in | (DW'(1) << BIT)) : root_in;
        pl_r[k]   <= pl_in;
      end
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_pl   = pl_r[SQ_STAGES-1];
  assign out_root = root_r[SQ_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/rmj_div.sv
// pipelined restoring divider with signed saturated result
`default_nettype none
module rmj_div import rmj_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NW-1:0]    num,
  input  logic [DIV_DW-1:0]    den,
  input  logic                 neg,
  input  logic                 zero,
  output logic signed [DW-1:0] quo
);

  logic [DIV_RW-1:0] rem_r  [DIV_STAGES];
  logic [DIV_DW-1:0] den_r  [DIV_STAGES];
  logic [DIV_QB-1:0] q_r    [DIV_STAGES];
  logic              neg_r  [DIV_STAGES];
  logic              zero_r [DIV_STAGES];
  logic              big_r  [DIV_STAGES];

  // overflow check: quotient reaches 2^DIV_QB
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DIV_RW'(num);
      den_r[0]  <= den;
      q_r[0]    <= '0;
      neg_r[0]  <= neg;
      zero_r[0] <= zero;
      big_r[0]  <= (DIV_RW'(num) >= (DIV_RW'(den) << DIV_QB));
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_st
    localparam int BIT = DIV_STAGES - 1 - k;
    logic [DIV_RW-1:0] trial;
    logic              take;

    assign trial = DIV_RW'(den_r[k-1]) << BIT;
    assign take  = (rem_r[k-1] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? (rem_r[k-1] - trial) : rem_r[k-1];
        q_r[k]    <= take ? (q_r[k-1] | (DIV_QB'(1) << BIT)) : q_r[k-1];
        den_r[k]  <= den_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        zero_r[k] <= zero_r[k-1];
        big_r[k]  <= big_r[k-1];
      end
    end
  end

  logic [DW-1:0] lim;
  logic [DW-1:0] low;

  always_comb begin
    lim = neg_r[DIV_STAGES-1] ? (DW'(1) << (DW - 1)) : ((DW'(1) << (DW - 1)) - DW'(1));
    low = DW'(q_r[DIV_STAGES-1]);
    if (big_r[DIV_STAGES-1] || (low > lim)) begin
      low = lim;
    end
    if (zero_r[DIV_STAGES-1]) begin
      quo = '0;
    end else if (neg_r[DIV_STAGES-1]) begin
      quo = $signed(DW'(0) - low);
    end else begin
      quo = $signed(low);
    end
  end

endmodule
`default_nettype wire

>>> rtl/radar_measurement_jacobian.sv
// top level: radar measurement jacobian pipeline with threshold register
`default_nettype none
// Radar measurement Jacobian for an extended Kalman filter. Each request carries a
// state vector (pos_x, pos_y, vel_x, vel_y, signed Q16.16) and yields one result with
// the six distinct nonzero Jacobian entries, truncated toward zero and saturated to
// Q16.16, plus div_error. When px^2 + py^2 is zero or below min_range_sq (unsigned Q32.16,
// reset 7, written through the cfg port, always ready) all entries are zero and
// div_error is set. The pipeline takes one request per cycle unless the result side
// stalls and passes from acceptance to the result register through three stages for
// magnitudes, products and range squared, 32 square root stages (one root bit
// each), two stages for the split 64x32 products, 33 divider stages (overflow check
// plus one quotient bit each) and the output register. A stall on the result side
// freezes the whole pipeline, so in_stall follows out_stall while a result waits.
module radar_measurement_jacobian import rmj_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rmj_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rmj_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic             adv;            // whole pipeline moves one step
  logic [CFG_W-1:0] min_range_sq_r;
  logic             out_valid_r;
  rmj_out_t         out_data_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_sq_r <= MIN_RANGE_SQ_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_range_sq_r <= cfg_data;
    end
  end

  // stage a: sign and magnitude of each input
  logic          a_vld_r;
  logic [DW-1:0] a_px_m_r, a_py_m_r, a_vx_m_r, a_vy_m_r;
  logic          a_px_n_r, a_py_n_r, a_vx_n_r, a_vy_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_px_m_r <= rmj_mag(in_data.pos_x);
      a_py_m_r <= rmj_mag(in_data.pos_y);
      a_vx_m_r <= rmj_mag(in_data.vel_x);
      a_vy_m_r <= rmj_mag(in_data.vel_y);
      a_px_n_r <= in_data.pos_x[DW-1];
      a_py_n_r <= in_data.pos_y[DW-1];
      a_vx_n_r <= in_data.vel_x[DW-1];
      a_vy_n_r <= in_data.vel_y[DW-1];
    end
  end

  // stage b: four 32x32 magnitude products
  logic            b_vld_r;
  logic [SQ_W-1:0] b_pxx_r, b_pyy_r, b_t1_r, b_t2_r;
  logic            b_t1_n_r, b_t2_n_r;
  logic [DW-1:0]   b_px_m_r, b_py_m_r;
  logic            b_px_n_r, b_py_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pxx_r  <= a_px_m_r * a_px_m_r;
      b_pyy_r  <= a_py_m_r * a_py_m_r;
      b_t1_r   <= a_vx_m_r * a_py_m_r;
      b_t2_r   <= a_vy_m_r * a_px_m_r;
      b_t1_n_r <= a_vx_n_r ^ a_py_n_r;
      b_t2_n_r <= a_vy_n_r ^ a_px_n_r;
      b_px_m_r <= a_px_m_r;
      b_py_m_r <= a_py_m_r;
      b_px_n_r <= a_px_n_r;
      b_py_n_r <= a_py_n_r;
    end
  end

  // stage c: range squared, threshold check, cross term vx*py - vy*px
  logic            c_vld_r;
  rmj_sq_pl_t      c_pl_r;
  logic [SQ_W-1:0] r2_nxt;
  logic [SQ_W-1:0] thr;
  logic            s2;          // sign of the subtracted term
  logic [SQ_W-1:0] cr_m_nxt;
  logic            cr_n_nxt;

  always_comb begin
    r2_nxt = b_pxx_r + b_pyy_r;
    thr    = SQ_W'(min_range_sq_r) << FB;
    s2     = !b_t2_n_r;
    if (b_t1_n_r == s2) begin
      cr_m_nxt = b_t1_r + b_t2_r;
      cr_n_nxt = b_t1_n_r;
    end else if (b_t1_r >= b_t2_r) begin
      cr_m_nxt = b_t1_r - b_t2_r;
      cr_n_nxt = b_t1_n_r;
    end else begin
      cr_m_nxt = b_t2_r - b_t1_r;
      cr_n_nxt = s2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_pl_r.err  <= (r2_nxt < thr) || (r2_nxt == '0);
      c_pl_r.r2   <= r2_nxt;
      c_pl_r.px_m <= b_px_m_r;
      c_pl_r.py_m <= b_py_m_r;
      c_pl_r.px_n <= b_px_n_r;
      c_pl_r.py_n <= b_py_n_r;
      c_pl_r.cr_m <= cr_m_nxt;
      c_pl_r.cr_n <= cr_n_nxt;
    end
  end

  // range = floor(sqrt(range squared))
  logic          sq_vld;
  rmj_sq_pl_t    sq_pl;
  logic [DW-1:0] sq_root;

  rmj_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (c_vld_r),
    .in_pl    (c_pl_r),
    .out_vld  (sq_vld),
    .out_pl   (sq_pl),
    .out_root (sq_root)
  );

  // stage p1: 64x32 products split into 32x32 halves
  logic          p1_vld_r;
  rmj_sq_pl_t    p1_pl_r;
  logic [DW-1:0] p1_r_r;
  logic [SQ_W-1:0] p1_r3_lo_r, p1_r3_hi_r, p1_nx_lo_r, p1_nx_hi_r, p1_ny_lo_r, p1_ny_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_pl_r    <= sq_pl;
      p1_r_r     <= sq_root;
      p1_r3_lo_r <= sq_pl.r2[DW-1:0] * sq_root;
      p1_r3_hi_r <= sq_pl.r2[SQ_W-1:DW] * sq_root;
      p1_nx_lo_r <= sq_pl.py_m * sq_pl.cr_m[DW-1:0];
      p1_nx_hi_r <= sq_pl.py_m * sq_pl.cr_m[SQ_W-1:DW];
      p1_ny_lo_r <= sq_pl.px_m * sq_pl.cr_m[DW-1:0];
      p1_ny_hi_r <= sq_pl.px_m * sq_pl.cr_m[SQ_W-1:DW];
    end
  end

  // stage p2: combine halves into range cubed and rate numerators
  logic              p2_vld_r;
  rmj_sq_pl_t        p2_pl_r;
  logic [DW-1:0]     p2_r_r;
  logic [DIV_DW-1:0] p2_r3_r, p2_nx_r, p2_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_pl_r <= p1_pl_r;
      p2_r_r  <= p1_r_r;
      p2_r3_r <= DIV_DW'(p1_r3_lo_r) + (DIV_DW'(p1_r3_hi_r) << DW);
      p2_nx_r <= DIV_DW'(p1_nx_lo_r) + (DIV_DW'(p1_nx_hi_r) << DW);
      p2_ny_r <= DIV_DW'(p1_ny_lo_r) + (DIV_DW'(p1_ny_hi_r) << DW);
    end
  end

  // six dividers in lockstep; valid and error ride alongside
  logic signed [DW-1:0] q0, q1, q2, q3, q4, q5;
  logic                 dv_r  [DIV_STAGES];
  logic                 der_r [DIV_STAGES];

  rmj_div u_div_rpx (
    .clk (clk), .en (adv),
    .num (DIV_NW'(p2_pl_r.px_m) << FB), .den (DIV_DW'(p2_r_r)),
    .neg (p2_pl_r.px_n), .zero (p2_pl_r.err), .quo (q0)
  );

  rmj_div u_div_rpy (
    .clk (clk), .en (adv),
    .num (DIV_NW'(p2_pl_r.py_m) << FB), .den (DIV_DW'(p2_r_r)),
    .neg (p2_pl_r.py_n), .zero (p2_pl_r.err), .quo (q1)
  );

  rmj_div u_div_bpx (
    .clk (clk), .en (adv),
    .num (DIV_NW'(p2_pl_r.py_m) << (2 * FB)), .den (DIV_DW'(p2_pl_r.r2)),
    .neg (!p2_pl_r.py_n), .zero (p2_pl_r.err), .quo (q2)
  );

  rmj_div u_div_bpy (
    .clk (clk), .en (adv),
    .num (DIV_NW'(p2_pl_r.px_m) << (2 * FB)), .den (DIV_DW'(p2_pl_r.r2)),
    .neg (p2_pl_r.px_n), .zero (p2_pl_r.err), .quo (q3)
  );

  rmj_div u_div_vpx (
    .clk (clk), .en (adv),
    .num (DIV_NW'(p2_nx_r) << FB), .den (p2_r3_r),
    .neg (p2_pl_r.py_n ^ p2_pl_r.cr_n), .zero (p2_pl_r.err), .quo (q4)
  );

  // rate wrt py takes the opposite sign of px times the cross term
  rmj_div u_div_vpy (
    .clk (clk), .en (adv),
    .num (DIV_NW'(p2_ny_r) << FB), .den (p2_r3_r),
    .neg (!(p2_pl_r.px_n ^ p2_pl_r.cr_n)), .zero (p2_pl_r.err), .quo (q5)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      dv_r[0] <= p2_vld_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      der_r[0] <= p2_pl_r.err;
      for (int i = 1; i < DIV_STAGES; i++) begin
        der_r[i] <= der_r[i-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.range_dpx   <= q0;
      out_data_r.range_dpy   <= q1;
      out_data_r.bearing_dpx <= q2;
      out_data_r.bearing_dpy <= q3;
      out_data_r.rate_dpx    <= q4;
      out_data_r.rate_dpy    <= q5;
      out_data_r.div_error   <= der_r[DIV_STAGES-1];
    end
  end

`ifndef SYNTHESIS
  // refused requests give all-zero entries
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.div_error |->
      out_data_r.range_dpx == '0 && out_data_r.range_dpy == '0 &&
      out_data_r.bearing_dpx == '0 && out_data_r.bearing_dpy == '0 &&
      out_data_r.rate_dpx == '0 && out_data_r.rate_dpy == '0)
    else $error("refused request with nonzero entry");

  // px over range never exceeds one in magnitude
  a_range_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.div_error |->
      out_data_r.range_dpx <= $signed(DW'(1) << FB) &&
      out_data_r.range_dpx >= -$signed(DW'(1) << FB))
    else $error("range_dpx beyond unit magnitude");

  // a request leaving the products enters the dividers
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    adv && p2_vld_r |=> dv_r[0])
    else $error("request lost entering dividers");

  // frozen pipeline keeps its last valid bit
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(dv_r[DIV_STAGES-1]))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
